@@ src/kdq_pkg.sv @@
// Package for the keyed deque core: operation codes, status codes and the
// command and status groups passed between the controller and the datapath.
// No dependencies.
`default_nettype none

package kdq_pkg;

	localparam int KEY_W = 32;

	// Operation codes carried on the kind port.
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_REMOVE     = 3'd3;
	localparam logic [2:0] KIND_PEEK       = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop;
		logic srch_init;
		logic srch_rd;
		logic srch_next;
		logic sh_rd;
		logic sh_wr;
		logic drop;
		logic front_rd;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic key_match;
		logic idx_last;
		logic shift_last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ src/kdq_dpath.sv @@
// Datapath of the keyed deque core: the record memory as a circular buffer,
// head pointer, record count, scan index and the registered read port.
// Depends on kdq_pkg.
`default_nettype none

module kdq_dpath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kdq_pkg::cmd_t         cmd,
	input  wire logic [31:0]           key,
	input  wire logic [DATA_WIDTH-1:0] record_data,
	output kdq_pkg::dp_stat_t          stat,
	output logic                       is_empty,
	output logic [31:0]                front_key,
	output logic [DATA_WIDTH-1:0]      front_data,
	output logic [4:0]                 entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = kdq_pkg::KEY_W + DATA_WIDTH;
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [RW-1:0] mem_q [DEPTH];
	logic [RW-1:0] rd_q;
	logic [AW-1:0] hd_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   key_q;

	logic [AW-1:0] hd_dec;
	logic [AW-1:0] hd_inc;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] idx_addr;
	logic [AW-1:0] idx_next_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [RW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// Logical position to physical slot, wrapping once around the buffer.
	function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
			input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	assign hd_dec        = (hd_q == '0) ? LAST_IDX : hd_q - AW'(1);
	assign hd_inc        = (hd_q == LAST_IDX) ? '0 : hd_q + AW'(1);
	assign tail_addr     = wrap_idx(hd_q, count_q[AW-1:0]);
	assign idx_addr      = wrap_idx(hd_q, idx_q);
	assign idx_next_addr = wrap_idx(hd_q, idx_q + AW'(1));

	always_comb begin
		wr_en   = cmd.push_front | cmd.push_back | cmd.sh_wr;
		wr_addr = idx_addr;
		wr_data = rd_q;
		if (cmd.push_front) begin
			wr_addr = hd_dec;
			wr_data = {key, record_data};
		end else if (cmd.push_back) begin
			wr_addr = tail_addr;
			wr_data = {key, record_data};
		end
	end

	always_comb begin
		rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.front_rd;
		rd_addr = hd_q;
		if (cmd.srch_rd) begin
			rd_addr = idx_addr;
		end else if (cmd.sh_rd) begin
			rd_addr = idx_next_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.srch_init) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q    <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.push_front) begin
				hd_q <= hd_dec;
			end else if (cmd.pop) begin
				hd_q <= hd_inc;
			end
			if (cmd.push_front || cmd.push_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop || cmd.drop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.srch_init) begin
				idx_q <= '0;
			end else if (cmd.srch_next || cmd.sh_wr) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_comb begin
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(DEPTH));
		stat.key_match  = (rd_q[RW-1 -: 32] == key_q);
		stat.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);
		// The copy being written in this state moves the final record up one place.
		stat.shift_last = ((CW + 1)'(idx_q) + (CW + 1)'(2)) >= (CW + 1)'(count_q);
	end

	assign is_empty    = (count_q == '0);
	assign front_key   = is_empty ? '0 : rd_q[RW-1 -: 32];
	assign front_data  = is_empty ? '0 : rd_q[DATA_WIDTH-1:0];
	assign entry_count = 5'(count_q);

endmodule

`default_nettype wire

@@ src/kdq_ctrl.sv @@
// Controller of the keyed deque core: sequences each operation, the key
// search and the gap closing, and holds the result status and strobe.
// Depends on kdq_pkg.
`default_nettype none

module kdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        kind,
	input  wire kdq_pkg::dp_stat_t stat,
	output kdq_pkg::cmd_t          cmd,
	output logic                   busy,
	output logic                   done,
	output logic [1:0]             status
);

	typedef enum logic [2:0] {
		IDLE,
		SRCH_RD,
		SRCH_CMP,
		SH_RD,
		SH_WR,
		FRONT_RD,
		RESULT
	} state_t;

	state_t           state_q;
	state_t           state_d;
	kdq_pkg::status_t status_q;
	kdq_pkg::status_t status_d;
	logic             done_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			IDLE: begin
				if (start) begin
					state_d  = FRONT_RD;
					status_d = kdq_pkg::ST_OK;
					case (kind)
						kdq_pkg::KIND_PUSH_FRONT: begin
							if (stat.full) begin
								status_d = kdq_pkg::ST_FULL;
							end else begin
								cmd.push_front = 1'b1;
							end
						end
						kdq_pkg::KIND_PUSH_BACK: begin
							if (stat.full) begin
								status_d = kdq_pkg::ST_FULL;
							end else begin
								cmd.push_back = 1'b1;
							end
						end
						kdq_pkg::KIND_POP_FRONT: begin
							if (stat.empty) begin
								status_d = kdq_pkg::ST_EMPTY;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						kdq_pkg::KIND_REMOVE: begin
							if (stat.empty) begin
								status_d = kdq_pkg::ST_NOT_FOUND;
							end else begin
								cmd.srch_init = 1'b1;
								state_d       = SRCH_RD;
							end
						end
						default: begin
							// Peek, and the unused codes, which behave as a peek.
							if (stat.empty) begin
								status_d = kdq_pkg::ST_EMPTY;
							end
						end
					endcase
				end
			end
			SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d     = SRCH_CMP;
			end
			SRCH_CMP: begin
				if (stat.key_match) begin
					status_d = kdq_pkg::ST_OK;
					if (stat.idx_last) begin
						cmd.drop = 1'b1;
						state_d  = FRONT_RD;
					end else begin
						state_d = SH_RD;
					end
				end else if (stat.idx_last) begin
					status_d = kdq_pkg::ST_NOT_FOUND;
					state_d  = FRONT_RD;
				end else begin
					cmd.srch_next = 1'b1;
					state_d       = SRCH_RD;
				end
			end
			SH_RD: begin
				cmd.sh_rd = 1'b1;
				state_d   = SH_WR;
			end
			SH_WR: begin
				cmd.sh_wr = 1'b1;
				if (stat.shift_last) begin
					cmd.drop = 1'b1;
					state_d  = FRONT_RD;
				end else begin
					state_d = SH_RD;
				end
			end
			FRONT_RD: begin
				cmd.front_rd = 1'b1;
				state_d      = RESULT;
			end
			RESULT: begin
				state_d = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			status_q <= kdq_pkg::ST_OK;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			done_q   <= (state_d == RESULT);
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign status = status_q;

endmodule

`default_nettype wire

@@ src/keyed_deque_with_removal_core.sv @@
// Keyed deque core: ordered store of DEPTH key and data records with push and
// pop at the front, push at the back, removal by key and peek.
// Depends on kdq_pkg, kdq_ctrl and kdq_dpath.
`default_nettype none

// An operation is taken when start is high while busy is low, and busy then
// stays high until its result has been shown. Each result beat is on the
// result ports for exactly one cycle, marked by done, and cannot be held
// off, so it must be captured in that cycle. Records live in a single-port
// memory used as a circular buffer, so push, pop and peek each run the
// operation, then the registered read of the front record, then the
// result beat, before the next operation can be taken. A removal scans
// from the front, reading and then comparing each record, then closes the
// gap by copying each later record up one place, again with a read and
// then a write per record, before the registered front read and result.
module keyed_deque_with_removal_core #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            kind,
	input  wire logic [31:0]           key,
	input  wire logic [DATA_WIDTH-1:0] record_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic                       is_empty,
	output logic [31:0]                front_key,
	output logic [DATA_WIDTH-1:0]      front_data,
	output logic [4:0]                 entry_count
);

	kdq_pkg::cmd_t     cmd;
	kdq_pkg::dp_stat_t stat;

	kdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	kdq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.record_data (record_data),
		.stat        (stat),
		.is_empty    (is_empty),
		.front_key   (front_key),
		.front_data  (front_data),
		.entry_count (entry_count)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted operation");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("core still busy after its result beat");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == kdq_pkg::ST_FULL) |-> (entry_count == 5'(DEPTH)))
		else $error("full status reported while the store was not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == kdq_pkg::ST_EMPTY) |-> is_empty)
		else $error("empty status reported with records held");
`endif

endmodule

`default_nettype wire

@@ test/keyed_deque_with_removal_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyed_deque_with_removal_core: push, pop, keyed removal
// and peek commands against a behavioural model of the record store.
// Depends on kdq_pkg and the core under test.
module keyed_deque_with_removal_core_tb;
	import kdq_pkg::*;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 64;
	localparam int RANDOM_CMDS = 900;

	// Kind values the core treats as a peek.
	localparam logic [2:0] KIND_RSVD_A = 3'd5;
	localparam logic [2:0] KIND_RSVD_B = 3'd6;
	localparam logic [2:0] KIND_RSVD_C = 3'd7;

	typedef struct {
		logic [2:0]        op;
		logic [31:0]       k;
		logic [DATA_W-1:0] d;
		int                idle_after;
		bit                drain;
	} deque_cmd_t;

	typedef struct {
		status_t           status;
		logic              is_empty;
		logic [31:0]       front_key;
		logic [DATA_W-1:0] front_data;
		logic [4:0]        entry_count;
	} deque_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [2:0]        kind = KIND_PEEK;
	logic [31:0]       key = '0;
	logic [DATA_W-1:0] record_data = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic              is_empty;
	logic [31:0]       front_key;
	logic [DATA_W-1:0] front_data;
	logic [4:0]        entry_count;

	deque_cmd_t    cmd_queue[$];
	deque_result_t awaited_results[$];
	int            total_cmds = 0;
	int            accepted_cmds = 0;
	int            mismatches = 0;
	int            idle_left = 0;
	bit            quiet = 0;
	logic [31:0]   pushed_keys[$];

	// Model copy of the store: position 0 is the front.
	logic [31:0]       model_keys[DEPTH];
	logic [DATA_W-1:0] model_data[DEPTH];
	int                model_held = 0;

	keyed_deque_with_removal_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.record_data(record_data),
		.done(done),
		.status(status),
		.is_empty(is_empty),
		.front_key(front_key),
		.front_data(front_data),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void drop_record(int pos);
		for (int i = pos; i + 1 < model_held; i++) begin
			model_keys[i] = model_keys[i + 1];
			model_data[i] = model_data[i + 1];
		end
		model_held--;
	endfunction

	function automatic deque_result_t apply_deque_op(logic [2:0] op, logic [31:0] k,
			logic [DATA_W-1:0] d);
		deque_result_t r;
		int hit;
		r.status = ST_OK;
		hit = -1;
		case (op)
			KIND_PUSH_FRONT: begin
				if (model_held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = model_held; i > 0; i--) begin
						model_keys[i] = model_keys[i - 1];
						model_data[i] = model_data[i - 1];
					end
					model_keys[0] = k;
					model_data[0] = d;
					model_held++;
				end
			end
			KIND_PUSH_BACK: begin
				if (model_held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_keys[model_held] = k;
					model_data[model_held] = d;
					model_held++;
				end
			end
			KIND_POP_FRONT: begin
				if (model_held == 0)
					r.status = ST_EMPTY;
				else
					drop_record(0);
			end
			KIND_REMOVE: begin
				for (int i = 0; i < model_held; i++)
					if (hit < 0 && model_keys[i] == k)
						hit = i;
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					drop_record(hit);
			end
			default: begin
				if (model_held == 0)
					r.status = ST_EMPTY;
			end
		endcase
		r.is_empty    = (model_held == 0);
		r.front_key   = (model_held == 0) ? '0 : model_keys[0];
		r.front_data  = (model_held == 0) ? '0 : model_data[0];
		r.entry_count = model_held[4:0];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < 40)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_cmd(logic [2:0] op, logic [31:0] k, logic [DATA_W-1:0] d, bit drain);
		deque_cmd_t c;
		c.op = op;
		c.k = k;
		c.d = d;
		c.idle_after = pick_idle();
		c.drain = drain;
		cmd_queue.push_back(c);
		if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK)
			pushed_keys.push_back(k);
		if (pushed_keys.size() > 24)
			void'(pushed_keys.pop_front());
	endtask

	// Mostly a small pool of keys, so that duplicates and successful removals are common.
	function automatic logic [31:0] pick_key(bit for_removal);
		int r;
		r = $urandom_range(0, 99);
		if (for_removal && r < 45 && pushed_keys.size() != 0)
			return pushed_keys[$urandom_range(0, pushed_keys.size() - 1)];
		else if (r < 75)
			return $urandom_range(0, 7);
		return $urandom;
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		return {$urandom, $urandom};
	endfunction

	// Driver: one new command per accepted beat, with idle gaps between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(apply_deque_op(kind, key, record_data));
				accepted_cmds++;
			end
			if (start && busy) begin
				// Beat not yet taken: hold everything.
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (cmd_queue.size() != 0 &&
					!(cmd_queue[0].drain && awaited_results.size() != 0)) begin
				kind <= cmd_queue[0].op;
				key <= cmd_queue[0].k;
				record_data <= cmd_queue[0].d;
				idle_left <= cmd_queue[0].idle_after;
				start <= 1'b1;
				void'(cmd_queue.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: a result beat is shown for one cycle only, so take it at this edge.
	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with no command outstanding");
			end else begin
				exp_r = awaited_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, expected %0d", status,
						exp_r.status));
				if (is_empty !== exp_r.is_empty)
					report_mismatch($sformatf("is_empty %b, expected %b", is_empty,
						exp_r.is_empty));
				if (front_key !== exp_r.front_key)
					report_mismatch($sformatf("front_key %h, expected %h", front_key,
						exp_r.front_key));
				if (front_data !== exp_r.front_data)
					report_mismatch($sformatf("front_data %h, expected %h", front_data,
						exp_r.front_data));
				if (entry_count !== exp_r.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count,
						exp_r.entry_count));
			end
		end
	end

	initial begin
		logic [2:0] op;
		bit filling;
		int r;

		// Directed part: empty store, extreme fields, full store, duplicates, last record.
		add_cmd(KIND_PEEK, 32'h0, '0, 0);
		add_cmd(KIND_POP_FRONT, 32'h0, '0, 0);
		add_cmd(KIND_REMOVE, 32'hFFFF_FFFF, '0, 0);
		add_cmd(KIND_RSVD_C, 32'h0, '1, 0);
		add_cmd(KIND_PUSH_BACK, 32'h0, '0, 0);
		add_cmd(KIND_PUSH_FRONT, 32'hFFFF_FFFF, '1, 0);
		add_cmd(KIND_REMOVE, 32'h0001_2345, pick_data(), 0);
		add_cmd(KIND_REMOVE, 32'hFFFF_FFFF, '0, 0);
		add_cmd(KIND_RSVD_A, 32'h0, '0, 0);
		add_cmd(KIND_PUSH_FRONT, 32'hA5, pick_data(), 0);
		for (int i = 0; i < 14; i++)
			add_cmd(KIND_PUSH_BACK, (i == 7) ? 32'hA5 : 32'h100 + i, pick_data(), 0);
		add_cmd(KIND_PUSH_FRONT, 32'h5A5A_5A5A, pick_data(), 0);
		add_cmd(KIND_PUSH_BACK, 32'hA5A5_A5A5, pick_data(), 0);
		add_cmd(KIND_REMOVE, 32'hA5, '0, 0);
		add_cmd(KIND_REMOVE, 32'h10D, '0, 0);
		add_cmd(KIND_RSVD_B, 32'h0, '0, 1);

		// Random part in blocks that lean towards filling or draining the store.
		filling = 1;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 40 == 0) begin
				filling = !filling;
				quiet = ($urandom_range(0, 2) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < (filling ? 65 : 25))
				op = r[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else if (r < (filling ? 75 : 60))
				op = KIND_POP_FRONT;
			else if (r < 90)
				op = KIND_REMOVE;
			else if (r < 97)
				op = KIND_PEEK;
			else
				case ($urandom_range(0, 2))
					0: op = KIND_RSVD_A;
					1: op = KIND_RSVD_B;
					default: op = KIND_RSVD_C;
				endcase
			add_cmd(op, pick_key(op == KIND_REMOVE), pick_data(), n % 200 == 199);
		end
		total_cmds = cmd_queue.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cmds < total_cmds || awaited_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
src/kdq_pkg.sv
src/kdq_dpath.sv
src/kdq_ctrl.sv
src/keyed_deque_with_removal_core.sv
test/keyed_deque_with_removal_core_tb.sv
